// ===== rtl/ctmh_pkg.sv =====
// Shared types and codes for the connection timeout min-heap.
package ctmh_pkg;

    localparam int ID_W     = 6;
    localparam int ID_SPACE = 64;
    localparam int REQ_W    = 3;
    localparam int ST_W     = 3;
    localparam int CFG_W    = 32;
    localparam int IN_TIME_W = 32;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 32'd60;

    localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd1;
    localparam logic [REQ_W-1:0] REQ_REACTIVATE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_EXPIRE     = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PRUNE      = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL   = 3'd1;
    localparam logic [ST_W-1:0] ST_BADID  = 3'd2;
    localparam logic [ST_W-1:0] ST_PRUNED = 3'd3;
    localparam logic [ST_W-1:0] ST_NONE   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SLOT, S_TAIL, S_UP_RD, S_UP_CMP,
        S_DN_L, S_DN_R, S_DN_CMP, S_FINAL, S_PR_START, S_PR_CHK
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_REG_INIT, DP_SLOT_RD, DP_UNREG, DP_REKEY,
        DP_TAKE_TAIL, DP_UP_RD, DP_UP_MOVE, DP_RD_L, DP_RD_R, DP_DN_MOVE,
        DP_FINAL, DP_PR_INIT, DP_ROOT_RD, DP_POP
    } t_dp_op;

    typedef enum logic [1:0] {
        SRC_REQ, SRC_PEND, SRC_ZERO
    } t_id_src;

    typedef struct packed {
        t_dp_op          op;
        logic            emit;
        logic [ST_W-1:0] emit_status;
        logic            emit_last;
        t_id_src         emit_src;
    } t_ctl;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             present;
        logic             full;
        logic             cnt_zero;
        logic             slot_ok;
        logic             pos_zero;
        logic             pos_eq_cnt;
        logic             up_less;
        logic             l_in;
        logic             dn_move;
        logic             expired;
        logic             pend_v;
    } t_sts;

endpackage

// ===== rtl/ctmh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ctmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/ctmh_datapath.sv =====
// Heap datapath: request registers, heap and slot memories, compare logic, result registers.
module ctmh_datapath
    import ctmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    output t_sts                 o_sts,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ID_W-1:0]      i_conn_id,
    input  logic [IN_TIME_W-1:0] i_now_time,
    output logic                 o_valid,
    output logic [ST_W-1:0]      o_status,
    output logic [ID_W-1:0]      o_out_id,
    output logic                 o_last
);
    localparam int POS_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int CW    = POS_W + 2;
    localparam int AGE_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int HW    = ID_W + TIME_BITS;

    logic [REQ_W-1:0]     r_req;
    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_now;
    logic [POS_W-1:0]     r_pos;
    logic [CNT_W-1:0]     r_cnt;
    logic [ID_W-1:0]      r_eid;
    logic [TIME_BITS-1:0] r_ekey;
    logic [ID_W-1:0]      r_cid;
    logic [TIME_BITS-1:0] r_ckey;
    logic                 r_use_r;
    logic [ID_SPACE-1:0]  r_present;
    logic [ID_W-1:0]      r_pend_id;
    logic                 r_pend_v;
    logic [CFG_W-1:0]     r_timeout;
    logic                 r_valid;
    logic [ST_W-1:0]      r_status;
    logic [ID_W-1:0]      r_out_id;
    logic                 r_last;

    logic [HW-1:0]        heap_rdata, heap_wdata;
    logic [POS_W-1:0]     heap_raddr;
    logic                 heap_we;
    logic [POS_W-1:0]     slot_rdata;
    logic [ID_W-1:0]      slot_waddr;
    logic                 slot_we;

    logic [ID_W-1:0]      rd_id;
    logic [TIME_BITS-1:0] rd_key;
    logic [CW-1:0]        l_idx, r_idx, cnt_x, pos_x;
    logic [POS_W-1:0]     parent;
    logic [CNT_W-1:0]     cnt_m1;
    logic                 take_r;
    logic [ID_W-1:0]      pick_id;
    logic [TIME_BITS-1:0] pick_key;
    logic [POS_W-1:0]     pick_pos;
    logic [TIME_BITS-1:0] age;
    logic [63:0]          now_ext;

    assign rd_id   = heap_rdata[HW-1:TIME_BITS];
    assign rd_key  = heap_rdata[TIME_BITS-1:0];
    assign pos_x   = CW'(r_pos);
    assign cnt_x   = CW'(r_cnt);
    assign l_idx   = (pos_x << 1) + CW'(1);
    assign r_idx   = l_idx + CW'(1);
    assign parent  = POS_W'((r_pos - POS_W'(1)) >> 1);
    assign cnt_m1  = r_cnt - CNT_W'(1);
    // on a tie the right child wins
    assign take_r  = r_use_r && !(r_ckey < rd_key);
    assign pick_id  = take_r ? rd_id : r_cid;
    assign pick_key = take_r ? rd_key : r_ckey;
    assign pick_pos = take_r ? r_idx[POS_W-1:0] : l_idx[POS_W-1:0];
    assign age      = r_now - rd_key;
    assign now_ext  = 64'(i_now_time);

    always_comb begin
        heap_we    = 1'b0;
        heap_wdata = {r_eid, r_ekey};
        heap_raddr = '0;
        slot_we    = 1'b0;
        slot_waddr = r_eid;
        case (i_ctl.op)
            DP_UP_RD:   heap_raddr = parent;
            DP_UNREG:   heap_raddr = cnt_m1[POS_W-1:0];
            DP_POP:     heap_raddr = cnt_m1[POS_W-1:0];
            DP_RD_L:    heap_raddr = l_idx[POS_W-1:0];
            DP_RD_R:    heap_raddr = r_idx[POS_W-1:0];
            DP_ROOT_RD: heap_raddr = '0;
            DP_UP_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = heap_rdata;
                slot_we    = 1'b1;
                slot_waddr = rd_id;
            end
            DP_DN_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = {pick_id, pick_key};
                slot_we    = 1'b1;
                slot_waddr = pick_id;
            end
            DP_FINAL: begin
                heap_we = 1'b1;
                slot_we = 1'b1;
            end
            default: ;
        endcase
    end

    ctmh_ram #(.WIDTH(HW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (heap_we),
        .i_waddr (r_pos),
        .i_wdata (heap_wdata),
        .i_raddr (heap_raddr),
        .o_rdata (heap_rdata)
    );

    ctmh_ram #(.WIDTH(POS_W), .DEPTH(ID_SPACE)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (r_pos),
        .i_raddr (r_id),
        .o_rdata (slot_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_present <= '0;
            r_pend_v  <= 1'b0;
            r_timeout <= TIMEOUT_RESET;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            case (i_ctl.op)
                DP_LOAD: begin
                    r_req <= i_req_type;
                    r_id  <= i_conn_id;
                    r_now <= now_ext[TIME_BITS-1:0];
                end
                DP_REG_INIT: begin
                    r_eid           <= r_id;
                    r_ekey          <= r_now;
                    r_pos           <= r_cnt[POS_W-1:0];
                    r_cnt           <= r_cnt + CNT_W'(1);
                    r_present[r_id] <= 1'b1;
                end
                DP_UNREG: begin
                    r_pos           <= slot_rdata;
                    r_cnt           <= cnt_m1;
                    r_present[r_id] <= 1'b0;
                end
                DP_REKEY: begin
                    r_pos  <= slot_rdata;
                    r_eid  <= r_id;
                    r_ekey <= (r_req == REQ_REACTIVATE) ? r_now : '0;
                end
                DP_TAKE_TAIL: begin
                    r_eid  <= rd_id;
                    r_ekey <= rd_key;
                end
                DP_UP_MOVE: r_pos <= parent;
                DP_RD_R: begin
                    r_cid   <= rd_id;
                    r_ckey  <= rd_key;
                    r_use_r <= r_idx < cnt_x;
                end
                DP_DN_MOVE: r_pos <= pick_pos;
                DP_PR_INIT: r_pend_v <= 1'b0;
                DP_POP: begin
                    r_pend_id        <= rd_id;
                    r_pend_v         <= 1'b1;
                    r_present[rd_id] <= 1'b0;
                    r_cnt            <= cnt_m1;
                    r_pos            <= '0;
                end
                default: ;
            endcase
            r_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            r_status <= i_ctl.emit_status;
            r_last   <= i_ctl.emit_last;
            case (i_ctl.emit_src)
                SRC_REQ:  r_out_id <= r_id;
                SRC_PEND: r_out_id <= r_pend_id;
                default:  r_out_id <= '0;
            endcase
        end
    end

    always_comb begin
        o_sts.req        = r_req;
        o_sts.present    = r_present[r_id];
        o_sts.full       = r_cnt >= CNT_W'(HEAP_DEPTH);
        o_sts.cnt_zero   = r_cnt == '0;
        o_sts.slot_ok    = CNT_W'(slot_rdata) < r_cnt;
        o_sts.pos_zero   = r_pos == '0;
        o_sts.pos_eq_cnt = pos_x == cnt_x;
        o_sts.up_less    = r_ekey < rd_key;
        o_sts.l_in       = l_idx < cnt_x;
        o_sts.dn_move    = r_ekey > pick_key;
        o_sts.expired    = AGE_W'(age) >= AGE_W'(r_timeout);
        o_sts.pend_v     = r_pend_v;
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_out_id = r_out_id;
    assign o_last   = r_last;
endmodule

// ===== rtl/ctmh_ctrl.sv =====
// Request sequencer: dispatch, sift up/down steps and the prune loop.
module ctmh_ctrl
    import ctmh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    output logic o_busy,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;
    logic   r_moved, n_moved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_moved <= n_moved;
        end
    end

    always_comb begin
        n_state = r_state;
        n_moved = r_moved;
        case (r_state)
            S_IDLE: if (i_start) n_state = S_DISP;
            S_DISP: begin
                n_moved = 1'b0;
                if (i_sts.req == REQ_REGISTER) begin
                    n_state = (i_sts.present || i_sts.full) ? S_IDLE : S_UP_RD;
                end else if (i_sts.req == REQ_PRUNE) begin
                    n_state = S_PR_START;
                end else if (i_sts.req == REQ_UNREGISTER || i_sts.req == REQ_REACTIVATE ||
                             i_sts.req == REQ_EXPIRE) begin
                    n_state = i_sts.present ? S_SLOT : S_IDLE;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SLOT: begin
                if (!i_sts.slot_ok) n_state = S_IDLE;
                else if (i_sts.req == REQ_UNREGISTER) n_state = S_TAIL;
                else n_state = S_UP_RD;
            end
            S_TAIL: begin
                n_moved = 1'b0;
                if (!i_sts.pos_eq_cnt) n_state = S_UP_RD;
                else if (i_sts.req == REQ_PRUNE) n_state = S_PR_START;
                else n_state = S_IDLE;
            end
            S_UP_RD: begin
                if (!i_sts.pos_zero) n_state = S_UP_CMP;
                else n_state = r_moved ? S_FINAL : S_DN_L;
            end
            S_UP_CMP: begin
                if (i_sts.up_less) begin
                    n_state = S_UP_RD;
                    n_moved = 1'b1;
                end else begin
                    n_state = r_moved ? S_FINAL : S_DN_L;
                end
            end
            S_DN_L:   n_state = i_sts.l_in ? S_DN_R : S_FINAL;
            S_DN_R:   n_state = S_DN_CMP;
            S_DN_CMP: n_state = i_sts.dn_move ? S_DN_L : S_FINAL;
            S_FINAL:  n_state = (i_sts.req == REQ_PRUNE) ? S_PR_START : S_IDLE;
            S_PR_START: n_state = i_sts.cnt_zero ? S_IDLE : S_PR_CHK;
            S_PR_CHK:   n_state = i_sts.expired ? S_TAIL : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl             = '0;
        o_ctl.op          = DP_NOP;
        o_ctl.emit_src    = SRC_REQ;
        o_ctl.emit_status = ST_OK;
        o_ctl.emit_last   = 1'b1;
        case (r_state)
            S_IDLE: if (i_start) o_ctl.op = DP_LOAD;
            S_DISP: begin
                if (i_sts.req == REQ_REGISTER) begin
                    if (i_sts.present) begin
                        o_ctl.emit        = 1'b1;
                        o_ctl.emit_status = ST_BADID;
                    end else if (i_sts.full) begin
                        o_ctl.emit        = 1'b1;
                        o_ctl.emit_status = ST_FULL;
                    end else begin
                        o_ctl.op = DP_REG_INIT;
                    end
                end else if (i_sts.req == REQ_PRUNE) begin
                    o_ctl.op = DP_PR_INIT;
                end else if (i_sts.req == REQ_UNREGISTER || i_sts.req == REQ_REACTIVATE ||
                             i_sts.req == REQ_EXPIRE) begin
                    if (i_sts.present) begin
                        o_ctl.op = DP_SLOT_RD;
                    end else begin
                        o_ctl.emit        = 1'b1;
                        o_ctl.emit_status = ST_BADID;
                    end
                end
            end
            S_SLOT: begin
                if (!i_sts.slot_ok) begin
                    o_ctl.emit        = 1'b1;
                    o_ctl.emit_status = ST_BADID;
                end else if (i_sts.req == REQ_UNREGISTER) begin
                    o_ctl.op = DP_UNREG;
                end else begin
                    o_ctl.op = DP_REKEY;
                end
            end
            S_TAIL: begin
                if (!i_sts.pos_eq_cnt) o_ctl.op = DP_TAKE_TAIL;
                else if (i_sts.req != REQ_PRUNE) o_ctl.emit = 1'b1;
            end
            S_UP_RD:  if (!i_sts.pos_zero) o_ctl.op = DP_UP_RD;
            S_UP_CMP: if (i_sts.up_less) o_ctl.op = DP_UP_MOVE;
            S_DN_L:   if (i_sts.l_in) o_ctl.op = DP_RD_L;
            S_DN_R:   o_ctl.op = DP_RD_R;
            S_DN_CMP: if (i_sts.dn_move) o_ctl.op = DP_DN_MOVE;
            S_FINAL: begin
                o_ctl.op   = DP_FINAL;
                o_ctl.emit = i_sts.req != REQ_PRUNE;
            end
            S_PR_START, S_PR_CHK: begin
                if (r_state == S_PR_START && !i_sts.cnt_zero) begin
                    o_ctl.op = DP_ROOT_RD;
                end else if (r_state == S_PR_CHK && i_sts.expired) begin
                    // previous pruned id goes out now that another follows
                    o_ctl.op          = DP_POP;
                    o_ctl.emit        = i_sts.pend_v;
                    o_ctl.emit_status = ST_PRUNED;
                    o_ctl.emit_last   = 1'b0;
                    o_ctl.emit_src    = SRC_PEND;
                end else begin
                    o_ctl.emit        = 1'b1;
                    o_ctl.emit_status = i_sts.pend_v ? ST_PRUNED : ST_NONE;
                    o_ctl.emit_src    = i_sts.pend_v ? SRC_PEND : SRC_ZERO;
                end
            end
            default: ;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
endmodule

// ===== rtl/connection_timeout_min_heap.sv =====
// Top level of the connection timeout min-heap timer queue.
// One request is taken at a time (start while not busy). Lookups, each sift-up level
// and each sift-down level go through the single read port of the heap RAM, and a
// prune keeps busy high while it pops each expired id in turn. The final result of a
// request shows in the same cycle that busy drops. Results appear as one-cycle
// strobes on o_valid and must be taken when shown; the receiver cannot stall them.
module connection_timeout_min_heap
    import ctmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 64,
    parameter int TIME_BITS  = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic                 i_cfg_we,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ID_W-1:0]      i_conn_id,
    input  logic [IN_TIME_W-1:0] i_now_time,
    output logic                 o_valid,
    output logic [ST_W-1:0]      o_status,
    output logic [ID_W-1:0]      o_out_id,
    output logic                 o_last
);
    t_ctl ctl;
    t_sts sts;

    ctmh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    ctmh_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_type  (i_req_type),
        .i_conn_id   (i_conn_id),
        .i_now_time  (i_now_time),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_last      (o_last)
    );

`ifndef SYNTH
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result strobe without a request in flight");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_busy)
        else $error("non-final result but sequencer idle");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_NONE || o_status == ST_OK)) |-> o_last)
        else $error("single-result status not marked last");
`endif
endmodule
